@@ src/hcd_pkg.sv @@
// Shared types, car state codes and scoring helpers for the hall-call dispatcher.
package hcd_pkg;

    localparam int CALL_W  = 6;   // width of the call mask fields of a result beat
    localparam int FLOOR_W = 4;   // width of the floor mask fields of a result beat
    localparam int SCORE_W = 9;   // holds the largest score (300)

    // Car state codes
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_UP      = 4'd1;
    localparam logic [3:0] ST_DOWN    = 4'd2;
    localparam logic [3:0] ST_DISP    = 4'd3;
    localparam logic [3:0] ST_DECEL   = 4'd4;
    localparam logic [3:0] ST_OPEN    = 4'd5;
    localparam logic [3:0] ST_CLOSING = 4'd6;
    localparam logic [3:0] ST_INDEP   = 4'd7;

    // Request codes
    localparam logic REQ_REGISTER = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    // Score offsets
    localparam logic [SCORE_W-1:0] SC_AHEAD   = 9'd1;
    localparam logic [SCORE_W-1:0] SC_IDLE    = 9'd50;
    localparam logic [SCORE_W-1:0] SC_DOORS   = 9'd60;
    localparam logic [SCORE_W-1:0] SC_BUSY    = 9'd70;
    localparam logic [SCORE_W-1:0] SC_PASSED  = 9'd100;
    localparam logic [SCORE_W-1:0] SC_OTHER   = 9'd300;

    typedef struct packed {
        logic       req_type;
        logic [2:0] call_floor;
        logic       call_up;
        logic [2:0] a_floor;
        logic [3:0] a_state;
        logic       a_emergency;
        logic [2:0] b_floor;
        logic [3:0] b_state;
        logic       b_emergency;
        logic       comm_fault;
    } hcd_in_t;

    typedef struct packed {
        logic [CALL_W-1:0]  pending_mask;
        logic [CALL_W-1:0]  car_a_calls;
        logic [CALL_W-1:0]  car_b_calls;
        logic [FLOOR_W-1:0] car_a_floors;
        logic [FLOOR_W-1:0] car_b_floors;
    } hcd_out_t;

    typedef struct packed {
        logic               refused;
        logic [SCORE_W-1:0] value;
    } hcd_score_t;

    // Cost of one car serving one call; lower is better.
    function automatic hcd_score_t score_car(input logic [2:0] floor, input logic [3:0] st,
                                             input logic emerg, input logic [3:0] tgt,
                                             input logic up);
        hcd_score_t         s;
        logic [3:0]         fl;
        logic [3:0]         span;
        logic [SCORE_W-1:0] d9;
        fl   = {1'b0, floor};
        span = (fl > tgt) ? (fl - tgt) : (tgt - fl);
        d9   = {5'd0, span};
        s.refused = 1'b0;
        s.value   = '0;
        if (emerg || st == ST_INDEP) begin
            s.refused = 1'b1;
        end else if (st == ST_IDLE && fl == tgt) begin
            s.value = '0;
        end else if (st == ST_UP && up) begin
            s.value = (fl < tgt) ? (SC_AHEAD + d9) : (SC_PASSED + d9);
        end else if (st == ST_DOWN && !up) begin
            s.value = (fl > tgt) ? (SC_AHEAD + d9) : (SC_PASSED + d9);
        end else if (st == ST_UP || st == ST_DOWN) begin
            s.refused = 1'b1;
        end else if (st == ST_DISP || st == ST_DECEL) begin
            s.value = SC_BUSY + d9;
        end else if (st == ST_IDLE) begin
            s.value = SC_IDLE + d9;
        end else if (st == ST_OPEN || st == ST_CLOSING) begin
            s.value = SC_DOORS + d9;
        end else begin
            s.value = SC_OTHER;
        end
        return s;
    endfunction

    // Car is stopped at the target floor and serves the call there.
    function automatic logic stopped_at(input logic [2:0] floor, input logic [3:0] st,
                                        input logic [3:0] tgt);
        logic hit;
        hit = ({1'b0, floor} == tgt) &&
              (st inside {ST_IDLE, ST_OPEN, ST_CLOSING, ST_DECEL});
        return hit;
    endfunction

endpackage

@@ src/hcd_cell.sv @@
// One hall-call cell: holds pending/assigned bits of a single call and extends the floor chain.
module hcd_cell #(
    parameter int FLOORS = 4,
    parameter int IDX    = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  hcd_pkg::hcd_in_t    ev,
    input  logic                ev_accept,
    input  logic [FLOORS-1:0]   a_floors_in,
    input  logic [FLOORS-1:0]   b_floors_in,
    output logic [FLOORS-1:0]   a_floors_out,
    output logic [FLOORS-1:0]   b_floors_out,
    output logic                pend_next,
    output logic                car_a_next,
    output logic                car_b_next,
    output logic                pend_q,
    output logic                car_a_q,
    output logic                car_b_q
);

    localparam int         FBIT = (IDX + 1) / 2;        // floor index, 0 is floor 1
    localparam logic [3:0] TGT  = 4'(FBIT + 1);
    localparam logic       UP   = ((IDX % 2) == 0);

    logic pend_reg, car_a_reg, car_b_reg;
    logic clr_a, clr_b, a1, b1;
    hcd_pkg::hcd_score_t sa, sb;

    always_comb begin
        clr_a = car_a_reg && hcd_pkg::stopped_at(ev.a_floor, ev.a_state, TGT);
        clr_b = !ev.comm_fault && car_b_reg &&
                hcd_pkg::stopped_at(ev.b_floor, ev.b_state, TGT);
        a1 = car_a_reg && !clr_a;
        b1 = car_b_reg && !clr_b;
        sa = hcd_pkg::score_car(ev.a_floor, ev.a_state, ev.a_emergency, TGT, UP);
        sb = hcd_pkg::score_car(ev.b_floor, ev.b_state, ev.b_emergency, TGT, UP);

        pend_next  = pend_reg;
        car_a_next = car_a_reg;
        car_b_next = car_b_reg;
        if (ev.req_type == hcd_pkg::REQ_REGISTER) begin
            if ({1'b0, ev.call_floor} == TGT && ev.call_up == UP &&
                !car_a_reg && !car_b_reg) begin
                pend_next = 1'b1;
            end
        end else if (ev.comm_fault) begin
            // car A absorbs everything
            car_a_next = a1 || b1 || pend_reg;
            car_b_next = 1'b0;
            pend_next  = 1'b0;
        end else begin
            car_a_next = a1;
            car_b_next = b1;
            if (pend_reg) begin
                if (a1 || b1) begin
                    pend_next = 1'b0;
                end else if (!(sa.refused && sb.refused)) begin
                    pend_next = 1'b0;
                    if (!sa.refused && (sb.refused || sa.value <= sb.value)) begin
                        car_a_next = 1'b1;
                    end else begin
                        car_b_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= 1'b0;
            car_a_reg <= 1'b0;
            car_b_reg <= 1'b0;
        end else if (ev_accept) begin
            pend_reg  <= pend_next;
            car_a_reg <= car_a_next;
            car_b_reg <= car_b_next;
        end
    end

    // merge this call's floor into the running floor masks
    always_comb begin
        a_floors_out = a_floors_in;
        b_floors_out = b_floors_in;
        a_floors_out[FBIT] = a_floors_in[FBIT] | car_a_next;
        b_floors_out[FBIT] = b_floors_in[FBIT] | car_b_next;
    end

    assign pend_q  = pend_reg;
    assign car_a_q = car_a_reg;
    assign car_b_q = car_b_reg;

endmodule

@@ src/two_car_hall_call_dispatcher_unit.sv @@
// Top level of the two-car hall-call dispatcher: a row of call cells and a skid output buffer.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------
//  s_      | in  | s_valid / s_ready | s_data  (hcd_pkg::hcd_in_t)
//  m_      | out | m_valid / m_ready | m_data  (hcd_pkg::hcd_out_t)
//
//  One beat per cycle sustained while the m_ side keeps taking results; each result is registered
//  in the output register, or in the skid slot when m_ stalls. All six (2*(FLOORS-1)) call cells
//  score and update in parallel in the accept cycle; the floor masks ripple through the cell row
//  within that same cycle. Reset (aresetn low, synchronous) clears all call masks and both output slots.
//  A stalled m_ side parks one result in a skid slot; s_ready drops only when both
//  the output register and the skid slot are full.
module two_car_hall_call_dispatcher_unit #(
    parameter int FLOORS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hcd_pkg::hcd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output hcd_pkg::hcd_out_t m_data
);

    localparam int NCALLS = 2 * (FLOORS - 1);

    logic accept;
    logic m_fire;

    // floor mask chain through the cell row
    logic [FLOORS-1:0] a_chain [NCALLS+1];
    logic [FLOORS-1:0] b_chain [NCALLS+1];

    logic [NCALLS-1:0] pend_next, car_a_next, car_b_next;
    logic [NCALLS-1:0] pend_q, car_a_q, car_b_q;

    hcd_pkg::hcd_out_t result;

    hcd_pkg::hcd_out_t out_data_reg, out_data_next;
    hcd_pkg::hcd_out_t skid_data_reg, skid_data_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_fire  = out_valid_reg && m_ready;

    assign a_chain[0] = '0;
    assign b_chain[0] = '0;

    // one cell per hall call, U1 D2 U2 D3 ...
    for (genvar k = 0; k < NCALLS; k++) begin : g_cell
        hcd_cell #(
            .FLOORS (FLOORS),
            .IDX    (k)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ev           (s_data),
            .ev_accept    (accept),
            .a_floors_in  (a_chain[k]),
            .b_floors_in  (b_chain[k]),
            .a_floors_out (a_chain[k+1]),
            .b_floors_out (b_chain[k+1]),
            .pend_next    (pend_next[k]),
            .car_a_next   (car_a_next[k]),
            .car_b_next   (car_b_next[k]),
            .pend_q       (pend_q[k]),
            .car_a_q      (car_a_q[k]),
            .car_b_q      (car_b_q[k])
        );
    end

    // fit the call and floor masks into the fixed-width result fields
    for (genvar i = 0; i < hcd_pkg::CALL_W; i++) begin : g_call_bit
        if (i < NCALLS) begin : g_used
            assign result.pending_mask[i] = pend_next[i];
            assign result.car_a_calls[i]  = car_a_next[i];
            assign result.car_b_calls[i]  = car_b_next[i];
        end else begin : g_pad
            assign result.pending_mask[i] = 1'b0;
            assign result.car_a_calls[i]  = 1'b0;
            assign result.car_b_calls[i]  = 1'b0;
        end
    end

    for (genvar i = 0; i < hcd_pkg::FLOOR_W; i++) begin : g_floor_bit
        if (i < FLOORS) begin : g_used
            assign result.car_a_floors[i] = a_chain[NCALLS][i];
            assign result.car_b_floors[i] = b_chain[NCALLS][i];
        end else begin : g_pad
            assign result.car_a_floors[i] = 1'b0;
            assign result.car_b_floors[i] = 1'b0;
        end
    end

    // output register plus one skid slot
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            // advance the parked beat once the output drains
            if (m_fire) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || m_fire) begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end else begin
                // hold the new beat behind the stalled one
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end else if (m_fire) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // a parked beat always sits behind a valid output beat
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot valid while output register empty");

    // no call is both pending and held by a car
    a_pend_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_q & (car_a_q | car_b_q)) == '0)
        else $error("pending call also assigned");

    // no call is held by both cars
    a_car_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        (car_a_q & car_b_q) == '0)
        else $error("call assigned to both cars");

    // a dispatch under link fault leaves car B and the pending set empty
    a_fault_drains_b: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.req_type == hcd_pkg::REQ_DISPATCH && s_data.comm_fault
        |=> car_b_q == '0 && pend_q == '0)
        else $error("fault dispatch left calls on car B or pending");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the two-car hall-call dispatcher: queued driver, stalling sink.
`timescale 1ns / 100ps

module tb_top;

    localparam int NCALL        = 6;          // U1 D2 U2 D3 U3 D4
    localparam int NO_TAKE      = 'hFFFF;     // cost of a car that may not take the call
    localparam int RAND_ITEMS   = 750;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;

    // State codes the package leaves unnamed: both fall into the catch-all cost
    localparam logic [3:0] ST_OTHER = 4'd8;
    localparam logic [3:0] ST_WILD  = 4'd15;

    // Sink stall patterns
    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    hcd_pkg::hcd_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    hcd_pkg::hcd_out_t m_data;

    hcd_pkg::hcd_in_t  stim_q[$];      // beats waiting to be driven
    hcd_pkg::hcd_out_t due_status[$];  // status beats the block still owes
    logic     running    = 1'b0;
    logic     beat_taken = 1'b0;
    int       fail_cnt   = 0;
    int       cycle_cnt  = 0;

    // Shadow copy of the three call masks
    logic [5:0] pend_calls = '0;
    logic [5:0] held_a     = '0;
    logic [5:0] held_b     = '0;

    two_car_hall_call_dispatcher_unit #(
        .FLOORS(4)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Dispatch arithmetic
    // ------------------------------------------------------------------

    // Floor served by call bit k; even bits are up calls
    function automatic int call_floor(int k);
        return (k + 1) / 2 + 1;
    endfunction

    // Cost of one car taking one call, lower wins; NO_TAKE when it may not
    function automatic int car_cost(logic [2:0] fl, logic [3:0] st, logic emerg,
                                    int tgt, logic up);
        int pos;
        int span;
        pos  = fl;
        span = (pos > tgt) ? pos - tgt : tgt - pos;
        if (emerg || st == hcd_pkg::ST_INDEP) return NO_TAKE;
        case (st)
            hcd_pkg::ST_IDLE:
                return (pos == tgt) ? 0 : int'(hcd_pkg::SC_IDLE) + span;
            hcd_pkg::ST_UP: begin
                if (!up) return NO_TAKE;
                return (pos < tgt) ? int'(hcd_pkg::SC_AHEAD) + span
                                   : int'(hcd_pkg::SC_PASSED) + span;
            end
            hcd_pkg::ST_DOWN: begin
                if (up) return NO_TAKE;
                return (pos > tgt) ? int'(hcd_pkg::SC_AHEAD) + span
                                   : int'(hcd_pkg::SC_PASSED) + span;
            end
            hcd_pkg::ST_DISP, hcd_pkg::ST_DECEL:
                return int'(hcd_pkg::SC_BUSY) + span;
            hcd_pkg::ST_OPEN, hcd_pkg::ST_CLOSING:
                return int'(hcd_pkg::SC_DOORS) + span;
            default:
                return int'(hcd_pkg::SC_OTHER);
        endcase
    endfunction

    // A car standing at the call floor in a serving state completes the call
    function automatic logic car_stopped_at(logic [2:0] fl, logic [3:0] st, int tgt);
        return (int'(fl) == tgt) &&
               (st == hcd_pkg::ST_IDLE || st == hcd_pkg::ST_OPEN ||
                st == hcd_pkg::ST_CLOSING || st == hcd_pkg::ST_DECEL);
    endfunction

    function automatic logic [3:0] floors_served(logic [5:0] calls);
        logic [3:0] fm;
        fm = '0;
        for (int k = 0; k < NCALL; k++)
            if (calls[k]) fm[call_floor(k) - 1] = 1'b1;
        return fm;
    endfunction

    // Apply one event to the shadow masks and return the status beat it yields
    function automatic hcd_pkg::hcd_out_t step_call_masks(hcd_pkg::hcd_in_t it);
        hcd_pkg::hcd_out_t res;
        int       tgt;
        int       ca;
        int       cb;
        res = '0;
        if (it.req_type == hcd_pkg::REQ_REGISTER) begin
            // Unknown floor/direction pairs match no bit and change nothing
            for (int k = 0; k < NCALL; k++) begin
                if (call_floor(k) == int'(it.call_floor) && ((k % 2) == 0) == it.call_up &&
                    !held_a[k] && !held_b[k])
                    pend_calls[k] = 1'b1;
            end
            res.car_a_floors = floors_served(held_a);
            res.car_b_floors = floors_served(held_b);
        end else begin
            // Drop calls a stopped car is serving; B keeps its calls on a fault
            for (int k = 0; k < NCALL; k++) begin
                tgt = call_floor(k);
                if (held_a[k] && car_stopped_at(it.a_floor, it.a_state, tgt))
                    held_a[k] = 1'b0;
                if (!it.comm_fault && held_b[k] && car_stopped_at(it.b_floor, it.b_state, tgt))
                    held_b[k] = 1'b0;
            end
            if (it.comm_fault) begin
                held_a     = held_a | held_b | pend_calls;
                held_b     = '0;
                pend_calls = '0;
                res.car_a_floors = floors_served(held_a);
                res.car_b_floors = '0;
            end else begin
                for (int k = 0; k < NCALL; k++) begin
                    if (pend_calls[k]) begin
                        if (held_a[k] || held_b[k]) begin
                            pend_calls[k] = 1'b0;
                        end else begin
                            tgt = call_floor(k);
                            ca  = car_cost(it.a_floor, it.a_state, it.a_emergency, tgt,
                                           (k % 2) == 0);
                            cb  = car_cost(it.b_floor, it.b_state, it.b_emergency, tgt,
                                           (k % 2) == 0);
                            // Both refused: leave the call pending
                            if (ca != NO_TAKE || cb != NO_TAKE) begin
                                if (ca != NO_TAKE && (cb == NO_TAKE || ca <= cb))
                                    held_a[k] = 1'b1;
                                else
                                    held_b[k] = 1'b1;
                                pend_calls[k] = 1'b0;
                            end
                        end
                    end
                end
                res.car_a_floors = floors_served(held_a);
                res.car_b_floors = floors_served(held_b);
            end
        end
        res.pending_mask = pend_calls;
        res.car_a_calls  = held_a;
        res.car_b_calls  = held_b;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    function automatic hcd_pkg::hcd_in_t hall_call(int fl, logic up);
        hcd_pkg::hcd_in_t it;
        it            = '0;
        it.req_type   = hcd_pkg::REQ_REGISTER;
        it.call_floor = fl[2:0];
        it.call_up    = up;
        return it;
    endfunction

    function automatic hcd_pkg::hcd_in_t car_status(int af, logic [3:0] ast, logic ae,
                                                    int bf, logic [3:0] bst, logic be,
                                                    logic fault);
        hcd_pkg::hcd_in_t it;
        it             = '0;
        it.req_type    = hcd_pkg::REQ_DISPATCH;
        it.a_floor     = af[2:0];
        it.a_state     = ast;
        it.a_emergency = ae;
        it.b_floor     = bf[2:0];
        it.b_state     = bst;
        it.b_emergency = be;
        it.comm_fault  = fault;
        return it;
    endfunction

    // Mostly served floors, now and then one no call sits on
    function automatic logic [2:0] pick_floor();
        return ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
    endfunction

    // Mostly listed states, now and then a code above the list
    function automatic logic [3:0] pick_state();
        return ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    endfunction

    function automatic hcd_pkg::hcd_in_t random_beat();
        hcd_pkg::hcd_in_t it;
        int      sel;
        int      k;
        // Start from noise so that ignored fields toggle too
        it             = hcd_pkg::hcd_in_t'($urandom);
        it.a_floor     = pick_floor();
        it.a_state     = pick_state();
        it.a_emergency = ($urandom_range(0, 6) == 0);
        it.b_floor     = pick_floor();
        it.b_state     = pick_state();
        it.b_emergency = ($urandom_range(0, 6) == 0);
        it.comm_fault  = ($urandom_range(0, 11) == 0);
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            // well-formed hall call
            k             = $urandom_range(0, NCALL - 1);
            it.req_type   = hcd_pkg::REQ_REGISTER;
            it.call_floor = 3'(call_floor(k));
            it.call_up    = ((k % 2) == 0);
        end else if (sel < 55) begin
            // raw floor/direction, often unknown
            it.req_type = hcd_pkg::REQ_REGISTER;
        end else begin
            it.req_type = hcd_pkg::REQ_DISPATCH;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: check outgoing beats, then predict from incoming ones.
    // One block owns both queues ends so no edge ordering matters.
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        hcd_pkg::hcd_out_t want;
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("two_car_hall_call_dispatcher_unit: mismatch");
            $finish;
        end
        running <= aresetn;
        if (aresetn && m_valid && m_ready) begin
            if (due_status.size() == 0) begin
                $error("status beat 0x%0h with nothing expected", m_data);
                fail_cnt++;
            end else begin
                want = due_status.pop_front();
                check_field("pending_mask", 8'(want.pending_mask), 8'(m_data.pending_mask));
                check_field("car_a_calls",  8'(want.car_a_calls),  8'(m_data.car_a_calls));
                check_field("car_b_calls",  8'(want.car_b_calls),  8'(m_data.car_b_calls));
                check_field("car_a_floors", 8'(want.car_a_floors), 8'(m_data.car_a_floors));
                check_field("car_b_floors", 8'(want.car_b_floors), 8'(m_data.car_b_floors));
            end
        end
        if (aresetn && s_valid && s_ready) begin
            due_status.push_back(step_call_masks(s_data));
            beat_taken <= 1'b1;
        end else begin
            beat_taken <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts of beats separated by random gaps, updated on the
    // falling edge. Hold valid and payload until the beat is taken.
    // ------------------------------------------------------------------

    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge aclk) begin
        logic send;
        send = 1'b0;
        if (running && !(s_valid && !beat_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (stim_q.size() > 0) begin
                send = 1'b1;
                s_data <= stim_q.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // close the burst: pick the next length and the gap before it
                    burst_left = $urandom_range(0, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            s_valid <= send;
        end
    end

    // ------------------------------------------------------------------
    // Sink: switch at random between stall patterns
    // ------------------------------------------------------------------

    rx_mode_e rx_mode   = RX_FREE;
    int       mode_left = 0;

    always @(negedge aclk) begin
        if (mode_left == 0) begin
            rx_mode   = rx_mode_e'($urandom_range(0, 3));
            mode_left = $urandom_range(10, 60);
        end else begin
            mode_left--;
        end
        case (rx_mode)
            RX_FREE:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
            default:   m_ready <= ((mode_left % 4) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Sequence: fill the stimulus queue, reset, drain, report
    // ------------------------------------------------------------------

    initial begin
        // Known calls, then floor/direction pairs that match no call
        stim_q.push_back(hall_call(1, 1'b1));
        stim_q.push_back(hall_call(4, 1'b0));
        stim_q.push_back(hall_call(2, 1'b0));
        stim_q.push_back(hall_call(3, 1'b1));
        stim_q.push_back(hall_call(0, 1'b1));
        stim_q.push_back(hall_call(4, 1'b1));
        stim_q.push_back(hall_call(1, 1'b0));
        stim_q.push_back(hall_call(7, 1'b0));
        // A idle at a call floor, B moving down from the top
        stim_q.push_back(car_status(1, hcd_pkg::ST_IDLE, 1'b0, 4, hcd_pkg::ST_DOWN,
                                    1'b0, 1'b0));
        // Re-register a call a car already holds
        stim_q.push_back(hall_call(1, 1'b1));
        stim_q.push_back(hall_call(2, 1'b1));
        stim_q.push_back(hall_call(3, 1'b0));
        stim_q.push_back(hall_call(4, 1'b0));
        // Both cars refuse: emergency stop and independent service
        stim_q.push_back(car_status(2, hcd_pkg::ST_IDLE, 1'b1, 3, hcd_pkg::ST_INDEP,
                                    1'b0, 1'b0));
        // Moving up with and against the calls, other state code
        stim_q.push_back(car_status(1, hcd_pkg::ST_UP, 1'b0, 2, ST_OTHER, 1'b0, 1'b0));
        stim_q.push_back(hall_call(1, 1'b1));
        stim_q.push_back(hall_call(3, 1'b1));
        // Equal costs go to car A
        stim_q.push_back(car_status(3, hcd_pkg::ST_DISP, 1'b0, 3, hcd_pkg::ST_DECEL,
                                    1'b0, 1'b0));
        stim_q.push_back(hall_call(2, 1'b0));
        stim_q.push_back(hall_call(4, 1'b0));
        stim_q.push_back(car_status(2, hcd_pkg::ST_OPEN, 1'b0, 2, hcd_pkg::ST_CLOSING,
                                    1'b0, 1'b0));
        stim_q.push_back(car_status(7, ST_WILD, 1'b0, 0, hcd_pkg::ST_DOWN, 1'b0, 1'b0));
        // Link fault: B's calls and all pending ones move to A
        stim_q.push_back(hall_call(2, 1'b1));
        stim_q.push_back(car_status(4, hcd_pkg::ST_DOWN, 1'b1, 1, hcd_pkg::ST_IDLE,
                                    1'b1, 1'b1));
        stim_q.push_back(car_status(4, hcd_pkg::ST_IDLE, 1'b0, 1, hcd_pkg::ST_UP,
                                    1'b0, 1'b0));
        for (int n = 0; n < RAND_ITEMS; n++)
            stim_q.push_back(random_beat());

        // Hold reset, then release it on a falling edge
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (stim_q.size() != 0 || s_valid) @(posedge aclk);
        while (due_status.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_cnt == 0) begin
            $display("two_car_hall_call_dispatcher_unit: match");
        end else begin
            $display("two_car_hall_call_dispatcher_unit: mismatch");
        end
        $finish;
    end

endmodule
